// ===== rtl/ola_pkg.sv =====
// Shared types and codes for the ordered list block.
// Used by ola_cell, ordered_list_append_delete and ola_checker.
package ola_pkg;

	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 3;
	localparam int ENTRIES_W = 5;
	localparam int OP_W      = 2;

	// Request operation codes.
	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	// Command broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic                      append;
		logic                      remove;
		logic                      rotate;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

// ===== rtl/ola_cell.sv =====
// One storage cell of the list row: holds a single entry and its position logic.
// Depends on ola_pkg for the command struct and value width.
module ola_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                               clk,
	input  ola_pkg::cell_cmd_t                 cmd,
	input  logic [CW-1:0]                      count,
	input  logic signed [ola_pkg::VALUE_W-1:0] right_data,
	input  logic signed [ola_pkg::VALUE_W-1:0] head_data,
	input  logic                               match_in,
	output logic                               match_out,
	output logic signed [ola_pkg::VALUE_W-1:0] data
);

	logic signed [ola_pkg::VALUE_W-1:0] data_q;
	logic occupied;
	logic tail_slot;
	logic last_pos;
	logic hit;

	// Position of this cell relative to the current fill level.
	assign occupied  = count > CW'(IDX);
	assign tail_slot = count == CW'(IDX);
	assign last_pos  = count == CW'(IDX + 1);

	// A match here or anywhere nearer the head means this cell closes the gap.
	assign hit       = occupied && (data_q == cmd.value);
	assign match_out = match_in || hit;
	assign data      = data_q;

	// Load a new tail value, shift toward the head on delete, or rotate on dump.
	always_ff @(posedge clk) begin
		if (cmd.append && tail_slot) begin
			data_q <= cmd.value;
		end else if (cmd.remove && occupied && match_out) begin
			data_q <= right_data;
		end else if (cmd.rotate && occupied) begin
			data_q <= last_pos ? head_data : right_data;
		end
	end

endmodule

// ===== rtl/ordered_list_append_delete.sv =====
// Top level of the ordered list: controller, output register and the cell row.
// Depends on ola_pkg and ola_cell.

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells, head
// in cell 0. An append or a delete gives one result: every cell compares its entry
// with the operand at once, and the cells from the first match onward take their
// right neighbor's value. A dump of n entries gives n results, one after another
// while the output is taken: the row rotates one place toward the head each cycle
// and the head cell feeds the output. A dump of an empty list gives one result. No
// new request is taken until the last result of a dump has been loaded into the
// output register. The store needs no clearing after reset.
module ordered_list_append_delete #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ola_pkg::OP_W-1:0]           operation,
	input  logic signed [ola_pkg::VALUE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ola_pkg::STATUS_W-1:0]       status,
	output logic signed [ola_pkg::VALUE_W-1:0] item_value,
	output logic [ola_pkg::ENTRIES_W-1:0]      entries,
	output logic                               last
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] left_q;
	logic          dumping_q;
	logic          out_valid_q;
	logic [ola_pkg::STATUS_W-1:0]       status_q;
	logic signed [ola_pkg::VALUE_W-1:0] item_value_q;
	logic [ola_pkg::ENTRIES_W-1:0]      entries_q;
	logic          last_q;

	logic          adv;
	logic          acc;
	logic          full;
	logic          found;
	logic          is_app;
	logic          is_del;
	logic          is_dump;
	ola_pkg::cell_cmd_t cmd;

	logic signed [ola_pkg::VALUE_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY:0] match_chain;

	logic                               res_valid;
	logic [ola_pkg::STATUS_W-1:0]       res_status;
	logic signed [ola_pkg::VALUE_W-1:0] res_value;
	logic [CW-1:0]                      res_count;
	logic                               res_last;

	// Handshake: the output slot is free when empty or being drained.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !dumping_q && adv;
	assign acc      = in_valid && in_ready;
	assign full     = count_q == CW'(CAPACITY);
	assign is_app   = acc && (operation == ola_pkg::OP_APPEND);
	assign is_del   = acc && (operation == ola_pkg::OP_DELETE);
	assign is_dump  = acc && (operation == ola_pkg::OP_DUMP);
	assign found    = match_chain[CAPACITY];

	// Command broadcast to the row.
	always_comb begin
		cmd.append = is_app && !full;
		cmd.remove = is_del && found;
		cmd.rotate = (is_dump && (count_q != '0)) || (dumping_q && adv);
		cmd.value  = value;
	end

	// Row of cells; each takes its right neighbor's value when shifting.
	assign match_chain[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ola_pkg::VALUE_W-1:0] right;
		if (i == CAPACITY - 1) begin : g_end
			assign right = cell_data[i];
		end else begin : g_mid
			assign right = cell_data[i + 1];
		end
		ola_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.right_data (right),
			.head_data  (cell_data[0]),
			.match_in   (match_chain[i]),
			.match_out  (match_chain[i + 1]),
			.data       (cell_data[i])
		);
	end

	// Result produced in this cycle, if any.
	always_comb begin
		res_valid  = 1'b0;
		res_status = ola_pkg::ST_ELEMENT;
		res_value  = value;
		res_count  = count_q;
		res_last   = 1'b1;
		if (dumping_q) begin
			res_valid = 1'b1;
			res_value = cell_data[0];
			res_last  = left_q == CW'(1);
		end else if (acc) begin
			unique case (operation)
				ola_pkg::OP_APPEND: begin
					res_valid = 1'b1;
					if (full) begin
						res_status = ola_pkg::ST_FULL;
					end else begin
						res_status = ola_pkg::ST_APPENDED;
						res_count  = count_q + CW'(1);
					end
				end
				ola_pkg::OP_DELETE: begin
					res_valid = 1'b1;
					if (found) begin
						res_status = ola_pkg::ST_REMOVED;
						res_count  = count_q - CW'(1);
					end else begin
						res_status = ola_pkg::ST_NOT_FOUND;
					end
				end
				ola_pkg::OP_DUMP: begin
					res_valid = 1'b1;
					if (count_q == '0) begin
						res_status = ola_pkg::ST_EMPTY;
						res_value  = '0;
					end else begin
						res_value = cell_data[0];
						res_last  = count_q == CW'(1);
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// Fill level and dump progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			left_q    <= '0;
			dumping_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.remove) begin
				count_q <= count_q - CW'(1);
			end
			if (dumping_q) begin
				if (adv) begin
					left_q <= left_q - CW'(1);
					if (left_q == CW'(1)) begin
						dumping_q <= 1'b0;
					end
				end
			end else if (is_dump && (count_q > CW'(1))) begin
				dumping_q <= 1'b1;
				left_q    <= count_q - CW'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			status_q     <= res_status;
			item_value_q <= res_value;
			entries_q    <= ola_pkg::ENTRIES_W'(res_count);
			last_q       <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign item_value = item_value_q;
	assign entries    = entries_q;
	assign last       = last_q;

endmodule

// ===== rtl/ola_checker.sv =====
// Port-level checks for the ordered list, bound to its top level.
// Depends on ola_pkg for the status codes.
module ola_port_checks #(
	parameter int CAPACITY = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [ola_pkg::STATUS_W-1:0]       status,
	input logic signed [ola_pkg::VALUE_W-1:0] item_value,
	input logic [ola_pkg::ENTRIES_W-1:0]      entries,
	input logic                               last
);

	// Only dump elements may be followed by more results of the same request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ola_pkg::ST_ELEMENT) |-> last)
		else $error("status result without last marker");

	// An empty dump reports a zero value and zero entries.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ola_pkg::ST_EMPTY) |-> (item_value == '0) && (entries == '0))
		else $error("empty dump with nonzero fields");

	// The entry count never goes above the capacity.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAPACITY > 31) || (entries <= ola_pkg::ENTRIES_W'(CAPACITY)))
		else $error("entry count above capacity");

	// A full report only appears with the list at capacity.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ola_pkg::ST_FULL) |->
			(CAPACITY > 31) || (entries == ola_pkg::ENTRIES_W'(CAPACITY)))
		else $error("full report below capacity");

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_value) && $stable(status))
		else $error("stalled result changed");

endmodule

bind ordered_list_append_delete ola_port_checks #(.CAPACITY(CAPACITY)) u_ola_checker (.*);
